FILE: design/wsp_pkg.sv
package wsp_pkg;

	localparam int NumStats  = 8;
	localparam int MaxWindow = 256;
	localparam int IdW       = 3;
	localparam int SlotW     = 8;
	localparam int LenW      = 9;
	localparam int AddrW     = IdW + SlotW;
	localparam int SumW      = 40;

	localparam logic [2:0] CMD_UPDATE = 3'd0;
	localparam logic [2:0] CMD_FRAME  = 3'd1;
	localparam logic [2:0] CMD_PREV   = 3'd2;
	localparam logic [2:0] CMD_PCT    = 3'd3;
	localparam logic [2:0] CMD_AVG    = 3'd4;

	localparam logic [0:0] REG_WINDOW_LENGTH  = 1'd0;
	localparam logic [0:0] REG_PROFILING_MODE = 1'd1;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  stat_id;
		logic [31:0] sample_time;
		logic [9:0]  percentile_tenths;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        profiling_done;
	} out_item_t;

endpackage

FILE: design/window_stats_percentile_avg_unit.sv
// channel  | signals                          | notes
// cmd      | start, busy, cmd_in              | accepted when start && !busy
// result   | res_valid, res_out               | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data
// Update: search then shift over one memory port. Average: one quotient bit per cycle.
// After reset and every window_length write, a clearing pass over all 2048 entries
// of the sample and sorted memories runs; busy stays high meanwhile.
// The receiver cannot stall a result; busy alone holds commands off.
module window_stats_percentile_avg_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  wsp_pkg::in_item_t       cmd_in,
	output logic                    res_valid,
	output wsp_pkg::out_item_t      res_out,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [0:0]              cfg_index,
	input  logic [31:0]             cfg_data
);
	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RDOLD  = 4'd2;
	localparam logic [3:0] ST_OLD    = 4'd3;
	localparam logic [3:0] ST_SRCH   = 4'd4;
	localparam logic [3:0] ST_SRCHW  = 4'd5;
	localparam logic [3:0] ST_SHRD   = 4'd6;
	localparam logic [3:0] ST_SHW    = 4'd7;
	localparam logic [3:0] ST_RDWAIT = 4'd8;
	localparam logic [3:0] ST_RDOUT  = 4'd9;
	localparam logic [3:0] ST_DIV    = 4'd10;
	localparam logic [3:0] ST_DONE   = 4'd11;
	localparam logic [3:0] ST_PCT    = 4'd12;

	logic [3:0]                   state_q;
	logic [wsp_pkg::LenW-1:0]     wlen_q;
	logic                         prof_q;
	logic [wsp_pkg::LenW-1:0]     slot_q;
	logic [wsp_pkg::SumW-1:0]     sums_q [wsp_pkg::NumStats];
	wsp_pkg::in_item_t            item_q;
	logic [wsp_pkg::AddrW-1:0]    clr_q;
	logic [wsp_pkg::LenW-1:0]     idx_q;
	logic [31:0]                  old_q;
	logic                         up_q;
	logic [31:0]                  rv_q;
	logic [wsp_pkg::LenW-1:0]     len;
	logic [wsp_pkg::LenW-1:0]     lm1;
	logic [31:0]                  smem [2**wsp_pkg::AddrW];
	logic [31:0]                  tmem [2**wsp_pkg::AddrW];
	logic [31:0]                  srd_q, trd_q;
	logic                         swe, twe;
	logic [wsp_pkg::AddrW-1:0]    saddr, taddr;
	logic [31:0]                  sdat, tdat;
	logic [9:0]                   pp;
	logic [18:0]                  pprod;
	logic [29:0]                  pmul;
	logic [wsp_pkg::LenW-1:0]     pidx;
	logic [wsp_pkg::SlotW-1:0]    prev_slot;
	logic [wsp_pkg::IdW-1:0]      sid;
	logic                         div_start;
	logic                         div_done;
	logic [wsp_pkg::SumW-1:0]     quot;
	logic [18:0]                  pprod_q;

	assign len = (wlen_q == '0) ? 9'd1 :
		(wlen_q > 9'(wsp_pkg::MaxWindow)) ? 9'(wsp_pkg::MaxWindow) : wlen_q;
	assign lm1 = len - 9'd1;
	assign sid = item_q.stat_id;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;

	// percentile index: (L-1)*(1000-p)/1000 via reciprocal, 2^30/1000 rounded up
	assign pp    = (cmd_in.percentile_tenths > 10'd1000) ? 10'd1000 : cmd_in.percentile_tenths;
	assign pprod = 19'(lm1) * 19'(10'd1000 - pp);
	assign pmul  = 30'((49'(pprod_q) * 49'd1073742) >> 30);
	assign pidx  = pmul[wsp_pkg::LenW-1:0];
	assign prev_slot = (slot_q == '0 || slot_q > len) ? lm1[wsp_pkg::SlotW-1:0]
		: 8'(slot_q - 9'd1);

	always_ff @(posedge clk) begin
		if (swe) smem[saddr] <= sdat;
		srd_q <= smem[saddr];
		if (twe) tmem[taddr] <= tdat;
		trd_q <= tmem[taddr];
	end

	always_comb begin
		swe = 1'b0; twe = 1'b0;
		saddr = {sid, slot_q[wsp_pkg::SlotW-1:0]};
		taddr = {sid, idx_q[wsp_pkg::SlotW-1:0]};
		sdat = item_q.sample_time; tdat = trd_q;
		div_start = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				swe = 1'b1; twe = 1'b1; saddr = clr_q; taddr = clr_q;
				sdat = '0; tdat = '0;
			end
			ST_RDWAIT: begin
				if (item_q.command == wsp_pkg::CMD_PREV)
					saddr = {sid, prev_slot};
			end
			ST_SHW: begin
				// write shifted neighbour into idx_q
				twe = 1'b1;
				taddr = {sid, idx_q[wsp_pkg::SlotW-1:0]};
			end
			ST_SHRD: begin
				taddr = up_q ? {sid, 8'(idx_q - 9'd1)} : {sid, 8'(idx_q + 9'd1)};
			end
			ST_DONE: begin
				twe = 1'b1; tdat = item_q.sample_time;
			end
			ST_OLD: begin
				if (item_q.sample_time != srd_q) swe = 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_RDWAIT && item_q.command == wsp_pkg::CMD_AVG) div_start = 1'b1;
	end

	wsp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sums_q[sid]), .divisor(len), .done(div_done), .quotient(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wlen_q <= 9'd256;
			prof_q <= 1'b0;
			slot_q <= '0;
			clr_q <= '0;
			res_valid <= 1'b0;
			res_out <= '0;
			item_q <= '0;
			pprod_q <= '0;
			rv_q <= '0;
			idx_q <= '0;
			old_q <= '0;
			up_q <= 1'b0;
			for (int i = 0; i < wsp_pkg::NumStats; i++) sums_q[i] <= '0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						item_q <= cmd_in;
						pprod_q <= pprod;
						rv_q <= '0;
						case (cmd_in.command)
							wsp_pkg::CMD_UPDATE: state_q <= (slot_q < len) ? ST_RDOLD : ST_RDOUT;
							wsp_pkg::CMD_FRAME: begin
								if (slot_q + 9'd1 >= len) slot_q <= prof_q ? len : '0;
								else slot_q <= slot_q + 9'd1;
								state_q <= ST_RDOUT;
							end
							wsp_pkg::CMD_PREV, wsp_pkg::CMD_AVG: state_q <= ST_RDWAIT;
							wsp_pkg::CMD_PCT: state_q <= ST_PCT;
							default: state_q <= ST_RDOUT;
						endcase
						up_q <= 1'b0;
					end else if (cfg_valid) begin
						if (cfg_index == wsp_pkg::REG_WINDOW_LENGTH) begin
							wlen_q <= cfg_data[wsp_pkg::LenW-1:0];
							slot_q <= '0;
							clr_q <= '0;
							state_q <= ST_CLEAR;
							for (int i = 0; i < wsp_pkg::NumStats; i++) sums_q[i] <= '0;
						end else prof_q <= cfg_data[0];
					end
				end
				ST_PCT: begin
					idx_q <= pidx;
					state_q <= ST_RDWAIT;
				end
				ST_RDOLD: state_q <= ST_OLD;
				ST_OLD: begin
					old_q <= srd_q;
					if (item_q.sample_time == srd_q) begin
						up_q <= 1'b0; state_q <= ST_RDOUT;
					end else begin
						sums_q[sid] <= sums_q[sid] - 40'(srd_q) + 40'(item_q.sample_time);
						up_q <= item_q.sample_time > srd_q;
						idx_q <= '0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: state_q <= ST_SRCHW;
				ST_SRCHW: begin
					// trd_q holds sorted[idx_q]
					if (trd_q == old_q) begin
						if (up_q ? (idx_q == '0) : (idx_q == lm1)) state_q <= ST_DONE;
						else state_q <= ST_SHRD;
					end else if (idx_q == lm1) begin
						state_q <= ST_RDOUT;
					end else begin
						idx_q <= idx_q + 9'd1;
						state_q <= ST_SRCH;
					end
				end
				ST_SHRD: state_q <= ST_SHW;
				ST_SHW: begin
					// trd_q is the neighbour, copied into idx_q; ST_DONE overwrites it if it stays
					if (up_q ? (trd_q < item_q.sample_time) : (trd_q > item_q.sample_time)) begin
						idx_q <= up_q ? idx_q - 9'd1 : idx_q + 9'd1;
						if (up_q ? (idx_q == 9'd1) : (idx_q + 9'd1 == lm1)) state_q <= ST_DONE;
						else state_q <= ST_SHRD;
					end else state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_RDOUT;
				ST_RDWAIT: begin
					if (item_q.command == wsp_pkg::CMD_AVG) state_q <= ST_DIV;
					else state_q <= ST_RDOUT;
				end
				ST_DIV: begin
					if (div_done) begin
						rv_q <= quot[31:0];
						state_q <= ST_RDOUT;
					end
				end
				ST_RDOUT: begin
					res_valid <= 1'b1;
					res_out.profiling_done <= prof_q && (slot_q >= len);
					if (sid >= 3'(wsp_pkg::NumStats - 1) + 3'd1 && wsp_pkg::NumStats < 8)
						res_out.read_value <= '0;
					else if (item_q.command == wsp_pkg::CMD_PREV) res_out.read_value <= srd_q;
					else if (item_q.command == wsp_pkg::CMD_PCT) res_out.read_value <= trd_q;
					else res_out.read_value <= rv_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: design/wsp_div.sv
// restoring divider, one quotient bit per cycle
module wsp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wsp_pkg::SumW-1:0]     dividend,
	input  logic [wsp_pkg::LenW-1:0]     divisor,
	output logic                         done,
	output logic [wsp_pkg::SumW-1:0]     quotient
);
	logic [wsp_pkg::SumW-1:0] q_q;
	logic [wsp_pkg::LenW:0]   rem_q;
	logic [wsp_pkg::LenW-1:0] div_q;
	logic [5:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [wsp_pkg::LenW:0]   trial;
	logic [wsp_pkg::LenW+1:0] diff;

	assign trial = {rem_q[wsp_pkg::LenW-1:0], q_q[wsp_pkg::SumW-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(wsp_pkg::SumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[wsp_pkg::LenW+1]) begin
				rem_q <= diff[wsp_pkg::LenW:0];
				q_q   <= {q_q[wsp_pkg::SumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[wsp_pkg::SumW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule
